// File: hdl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared widths, codes and types for the request tag tracker.
// ----------------------------------------------------------------------------
package rtt_pkg;

   localparam int ACTION_W     = 2;
   localparam int METHOD_W     = 8;
   localparam int TAG_W        = 8;
   localparam int LEN_W        = 32;
   localparam int KIND_W       = 8;
   localparam int STATUS_W     = 3;

   localparam int TAG_SLOTS    = 256;
   localparam int GROUP_W      = 16;
   localparam int NUM_GROUPS   = TAG_SLOTS / GROUP_W;
   localparam int GIDX_W       = $clog2(GROUP_W);
   localparam int GSEL_W       = TAG_W - GIDX_W;

   localparam int NUM_TAGS_DEF = 256;
   localparam int HEADER_BYTES = 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SEND    = 2'd0,
      ACT_HEADER  = 2'd1,
      ACT_PAYLOAD = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 3'd0,
      STAT_TABLE_FULL  = 3'd1,
      STAT_UNKNOWN_TAG = 3'd2,
      STAT_TOO_LONG    = 3'd3,
      STAT_PENDING     = 3'd4,
      STAT_OVERRUN     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SETTLE,
      S_SETTLE2
   } state_type;

   typedef struct packed {
      logic             set_en;
      logic             clr_en;
      logic [TAG_W-1:0] tag;
   } tag_upd_type;

   typedef struct packed {
      logic             found;
      logic [TAG_W-1:0] tag;
   } free_info_type;

endpackage

// File: hdl/rtt_limit_mem.sv
// ----------------------------------------------------------------------------
// rtt_limit_mem
// Per-tag response limit store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rtt_limit_mem #(
   parameter int NUM_TAGS = rtt_pkg::NUM_TAGS_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(NUM_TAGS)-1:0] wr_addr,
   input  logic [rtt_pkg::LEN_W-1:0]  wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(NUM_TAGS)-1:0] rd_addr,
   output logic [rtt_pkg::LEN_W-1:0]  rd_data
);
   import rtt_pkg::*;

   logic [LEN_W-1:0] mem_ff [NUM_TAGS];
   logic [LEN_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/rtt_tag_alloc.sv
// ----------------------------------------------------------------------------
// rtt_tag_alloc
// Tag busy bits with a two-stage registered search for the lowest free tag.
// ----------------------------------------------------------------------------
module rtt_tag_alloc #(
   parameter int NUM_TAGS = rtt_pkg::NUM_TAGS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rtt_pkg::tag_upd_type         upd,
   input  logic [rtt_pkg::TAG_W-1:0]    query_tag,
   output logic                         query_known,
   output rtt_pkg::free_info_type       free_info
);
   import rtt_pkg::*;

   localparam int TagIdxW = $clog2(NUM_TAGS);

   logic [NUM_TAGS-1:0]   busy_ff;
   logic [TAG_SLOTS-1:0]  free_vec;

   logic [NUM_GROUPS-1:0] grp_any_in;
   logic [NUM_GROUPS-1:0] grp_any_ff;
   logic [GIDX_W-1:0]     grp_idx_in [NUM_GROUPS];
   logic [GIDX_W-1:0]     grp_idx_ff [NUM_GROUPS];
   free_info_type         free_in;
   free_info_type         free_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         if (upd.set_en) begin
            busy_ff[upd.tag[TagIdxW-1:0]] <= 1'b1;
         end
         if (upd.clr_en) begin
            busy_ff[upd.tag[TagIdxW-1:0]] <= 1'b0;
         end
      end
   end

   for (genvar g = 0; g < TAG_SLOTS; g++) begin : g_free
      if (g < NUM_TAGS) begin : g_live
         assign free_vec[g] = ~busy_ff[g];
      end else begin : g_pad
         assign free_vec[g] = 1'b0;
      end
   end

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any_in[g] = |free_vec[g*GROUP_W +: GROUP_W];
         grp_idx_in[g] = '0;
         for (int j = GROUP_W - 1; j >= 0; j--) begin
            if (free_vec[g*GROUP_W + j]) begin
               grp_idx_in[g] = GIDX_W'(j);
            end
         end
      end
   end

   always_comb begin
      free_in = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            free_in.found = 1'b1;
            free_in.tag   = {GSEL_W'(g), grp_idx_ff[g]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_any_ff <= '0;
         free_ff    <= '0;
      end else begin
         grp_any_ff <= grp_any_in;
         free_ff    <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_idx_ff[g] <= grp_idx_in[g];
      end
   end

   assign free_info   = free_ff;
   assign query_known = ({1'b0, query_tag} < (TAG_W + 1)'(NUM_TAGS))
                        && busy_ff[query_tag[TagIdxW-1:0]];

endmodule

// File: hdl/request_tag_tracker_top.sv
// ----------------------------------------------------------------------------
// request_tag_tracker_top
// Outstanding request tag tracker: tag allocation, response matching and
// payload accounting.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request passes
// through the accept cycle in S_IDLE, then S_EXEC for the registered read of
// the limit memory and the update, then S_SETTLE and S_SETTLE2 while the
// registered lowest-free-tag search settles on the new busy bits; busy stays
// high until the return to S_IDLE. The result is driven for one cycle
// with rsp_valid, starting one cycle after the accept edge, and must be
// taken then since the receiver cannot stall. After reset, busy stays high
// through S_SETTLE and S_SETTLE2 while the free-tag search fills.
module request_tag_tracker_top #(
   parameter int NUM_TAGS = rtt_pkg::NUM_TAGS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rtt_pkg::ACTION_W-1:0]  req_action,
   input  logic [rtt_pkg::METHOD_W-1:0]  req_method,
   input  logic [rtt_pkg::LEN_W-1:0]     req_request_total_len,
   input  logic [rtt_pkg::LEN_W-1:0]     req_max_response_size,
   input  logic [rtt_pkg::TAG_W-1:0]     req_response_tag,
   input  logic [rtt_pkg::LEN_W-1:0]     req_response_len,
   input  logic [rtt_pkg::KIND_W-1:0]    req_response_kind,
   input  logic [rtt_pkg::LEN_W-1:0]     req_consumed_bytes,
   output logic                          rsp_valid,
   output logic [rtt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rtt_pkg::TAG_W-1:0]     rsp_tag_out,
   output logic [rtt_pkg::METHOD_W-1:0]  rsp_method_out,
   output logic [rtt_pkg::LEN_W-1:0]     rsp_request_payload_len,
   output logic [rtt_pkg::LEN_W-1:0]     rsp_matched_len,
   output logic [rtt_pkg::KIND_W-1:0]    rsp_matched_kind,
   output logic [rtt_pkg::LEN_W-1:0]     rsp_payload_left,
   output logic                          rsp_header_expected
);
   import rtt_pkg::*;

   localparam int TagIdxW = $clog2(NUM_TAGS);

   state_type            state_ff;
   state_type            state_in;
   logic                 accept;

   action_type           action_ff;
   logic [METHOD_W-1:0]  method_ff;
   logic [LEN_W-1:0]     total_len_ff;
   logic [LEN_W-1:0]     max_resp_ff;
   logic [TAG_W-1:0]     resp_tag_ff;
   logic [LEN_W-1:0]     resp_len_ff;
   logic [KIND_W-1:0]    resp_kind_ff;
   logic [LEN_W-1:0]     consumed_ff;

   logic [LEN_W-1:0]     remaining_ff;
   logic [LEN_W-1:0]     remaining_in;

   tag_upd_type          upd;
   free_info_type        free_info;
   logic                 tag_known;
   logic                 mem_wr_en;
   logic [LEN_W-1:0]     limit_rd;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   status_type           status_ff;
   status_type           status_in;
   logic [TAG_W-1:0]     tag_out_ff;
   logic [TAG_W-1:0]     tag_out_in;
   logic [METHOD_W-1:0]  method_out_ff;
   logic [METHOD_W-1:0]  method_out_in;
   logic [LEN_W-1:0]     plen_ff;
   logic [LEN_W-1:0]     plen_in;
   logic [LEN_W-1:0]     mlen_ff;
   logic [LEN_W-1:0]     mlen_in;
   logic [KIND_W-1:0]    mkind_ff;
   logic [KIND_W-1:0]    mkind_in;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff    <= action_type'(req_action);
         method_ff    <= req_method;
         total_len_ff <= req_request_total_len;
         max_resp_ff  <= req_max_response_size;
         resp_tag_ff  <= req_response_tag;
         resp_len_ff  <= req_response_len;
         resp_kind_ff <= req_response_kind;
         consumed_ff  <= req_consumed_bytes;
      end
   end

   rtt_limit_mem #(
      .NUM_TAGS (NUM_TAGS)
   ) u_limit_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (free_info.tag[TagIdxW-1:0]),
      .wr_data (max_resp_ff),
      .rd_en   (accept),
      .rd_addr (req_response_tag[TagIdxW-1:0]),
      .rd_data (limit_rd)
   );

   rtt_tag_alloc #(
      .NUM_TAGS (NUM_TAGS)
   ) u_tag_alloc (
      .clock       (clock),
      .reset       (reset),
      .upd         (upd),
      .query_tag   (resp_tag_ff),
      .query_known (tag_known),
      .free_info   (free_info)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SETTLE;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC) begin
         status_ff     <= status_in;
         tag_out_ff    <= tag_out_in;
         method_out_ff <= method_out_in;
         plen_ff       <= plen_in;
         mlen_ff       <= mlen_in;
         mkind_ff      <= mkind_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      remaining_in  = remaining_ff;
      rsp_valid_in  = 1'b0;
      upd           = '0;
      mem_wr_en     = 1'b0;
      status_in     = STAT_OK;
      tag_out_in    = '0;
      method_out_in = '0;
      plen_in       = '0;
      mlen_in       = '0;
      mkind_in      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = S_SETTLE;
            case (action_ff)
               ACT_SEND: begin
                  if (!free_info.found) begin
                     status_in = STAT_TABLE_FULL;
                  end else begin
                     upd.set_en    = 1'b1;
                     upd.tag       = free_info.tag;
                     mem_wr_en     = 1'b1;
                     tag_out_in    = free_info.tag;
                     method_out_in = method_ff;
                     if (total_len_ff > LEN_W'(HEADER_BYTES)) begin
                        plen_in = total_len_ff - LEN_W'(HEADER_BYTES);
                     end
                  end
               end
               ACT_HEADER: begin
                  tag_out_in = resp_tag_ff;
                  if (remaining_ff != '0) begin
                     status_in = STAT_PENDING;
                  end else if (!tag_known) begin
                     status_in = STAT_UNKNOWN_TAG;
                  end else begin
                     upd.clr_en   = 1'b1;
                     upd.tag      = resp_tag_ff;
                     remaining_in = resp_len_ff;
                     mlen_in      = resp_len_ff;
                     mkind_in     = resp_kind_ff;
                     if (resp_len_ff > limit_rd) begin
                        status_in = STAT_TOO_LONG;
                     end
                  end
               end
               ACT_PAYLOAD: begin
                  if (consumed_ff > remaining_ff) begin
                     status_in    = STAT_OVERRUN;
                     remaining_in = '0;
                  end else begin
                     remaining_in = remaining_ff - consumed_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SETTLE: begin
            state_in = S_SETTLE2;
         end
         S_SETTLE2: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = status_ff;
   assign rsp_tag_out             = tag_out_ff;
   assign rsp_method_out          = method_out_ff;
   assign rsp_request_payload_len = plen_ff;
   assign rsp_matched_len         = mlen_ff;
   assign rsp_matched_kind        = mkind_ff;
   assign rsp_payload_left        = remaining_ff;
   assign rsp_header_expected     = (remaining_ff == '0);

endmodule

// File: verif/request_tag_tracker_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// request_tag_tracker_checker
// Watches the request and response ports of the tag tracker, keeps its own
// tag table and payload count, and compares every response field against
// the reply worked out for the oldest accepted request.
// ----------------------------------------------------------------------------
module request_tag_tracker_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [rtt_pkg::ACTION_W-1:0] req_action,
   input  logic [rtt_pkg::METHOD_W-1:0] req_method,
   input  logic [rtt_pkg::LEN_W-1:0]    req_request_total_len,
   input  logic [rtt_pkg::LEN_W-1:0]    req_max_response_size,
   input  logic [rtt_pkg::TAG_W-1:0]    req_response_tag,
   input  logic [rtt_pkg::LEN_W-1:0]    req_response_len,
   input  logic [rtt_pkg::KIND_W-1:0]   req_response_kind,
   input  logic [rtt_pkg::LEN_W-1:0]    req_consumed_bytes,
   input  logic                         rsp_valid,
   input  logic [rtt_pkg::STATUS_W-1:0] rsp_status,
   input  logic [rtt_pkg::TAG_W-1:0]    rsp_tag_out,
   input  logic [rtt_pkg::METHOD_W-1:0] rsp_method_out,
   input  logic [rtt_pkg::LEN_W-1:0]    rsp_request_payload_len,
   input  logic [rtt_pkg::LEN_W-1:0]    rsp_matched_len,
   input  logic [rtt_pkg::KIND_W-1:0]   rsp_matched_kind,
   input  logic [rtt_pkg::LEN_W-1:0]    rsp_payload_left,
   input  logic                         rsp_header_expected,
   output int                           mismatch_count,
   output int                           replies_pending
);
   import rtt_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    tag;
      logic [METHOD_W-1:0] method;
      logic [LEN_W-1:0]    payload_len;
      logic [LEN_W-1:0]    matched_len;
      logic [KIND_W-1:0]   matched_kind;
      logic [LEN_W-1:0]    payload_left;
      logic                header_expected;
   } reply_type;

   logic [TAG_SLOTS-1:0] tag_held;
   logic [LEN_W-1:0]     tag_ceiling [TAG_SLOTS];
   logic [LEN_W-1:0]     bytes_owed;
   reply_type            outstanding_replies [$];
   int                   mismatches = 0;

   function automatic reply_type apply_request(
      input logic [ACTION_W-1:0] action,
      input logic [METHOD_W-1:0] method,
      input logic [LEN_W-1:0]    total_len,
      input logic [LEN_W-1:0]    max_resp,
      input logic [TAG_W-1:0]    resp_tag,
      input logic [LEN_W-1:0]    resp_len,
      input logic [KIND_W-1:0]   resp_kind,
      input logic [LEN_W-1:0]    consumed
   );
      reply_type rp;
      int        free_tag;
      rp = '0;
      rp.status = STAT_OK;
      case (action)
         ACT_SEND: begin
            free_tag = -1;
            for (int i = NUM_TAGS_DEF - 1; i >= 0; i--)
               if (!tag_held[i]) free_tag = i;
            if (free_tag < 0) begin
               rp.status = STAT_TABLE_FULL;
            end else begin
               tag_held[free_tag]    = 1'b1;
               tag_ceiling[free_tag] = max_resp;
               rp.tag                = free_tag[TAG_W-1:0];
               rp.method             = method;
               rp.payload_len        = (total_len > LEN_W'(HEADER_BYTES)) ?
                                       total_len - LEN_W'(HEADER_BYTES) : '0;
            end
         end
         ACT_HEADER: begin
            rp.tag = resp_tag;
            if (bytes_owed != 0) begin
               rp.status = STAT_PENDING;
            end else if (!tag_held[resp_tag]) begin
               rp.status = STAT_UNKNOWN_TAG;
            end else begin
               tag_held[resp_tag] = 1'b0;
               if (resp_len > tag_ceiling[resp_tag]) rp.status = STAT_TOO_LONG;
               bytes_owed      = resp_len;
               rp.matched_len  = resp_len;
               rp.matched_kind = resp_kind;
            end
         end
         ACT_PAYLOAD: begin
            if (consumed > bytes_owed) begin
               rp.status  = STAT_OVERRUN;
               bytes_owed = '0;
            end else begin
               bytes_owed = bytes_owed - consumed;
            end
         end
         default: ;
      endcase
      rp.payload_left    = bytes_owed;
      rp.header_expected = (bytes_owed == 0);
      return rp;
   endfunction

   task automatic check_field(input string name, input logic [LEN_W-1:0] want,
                              input logic [LEN_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         tag_held   = '0;
         bytes_owed = '0;
         outstanding_replies.delete();
      end else begin
         if (rsp_valid) begin
            if (outstanding_replies.size() == 0) begin
               $display("%0t: response expected none actual status %0h tag %0h left %0h",
                        $time, rsp_status, rsp_tag_out, rsp_payload_left);
               mismatches++;
            end else begin
               want = outstanding_replies.pop_front();
               check_field("status", LEN_W'(want.status), LEN_W'(rsp_status));
               check_field("tag_out", LEN_W'(want.tag), LEN_W'(rsp_tag_out));
               check_field("method_out", LEN_W'(want.method),
                           LEN_W'(rsp_method_out));
               check_field("request_payload_len", want.payload_len,
                           rsp_request_payload_len);
               check_field("matched_len", want.matched_len, rsp_matched_len);
               check_field("matched_kind", LEN_W'(want.matched_kind),
                           LEN_W'(rsp_matched_kind));
               check_field("payload_left", want.payload_left, rsp_payload_left);
               check_field("header_expected", LEN_W'(want.header_expected),
                           LEN_W'(rsp_header_expected));
            end
         end
         if (start && !busy)
            outstanding_replies.push_back(apply_request(
               req_action, req_method, req_request_total_len, req_max_response_size,
               req_response_tag, req_response_len, req_response_kind,
               req_consumed_bytes));
      end
      mismatch_count  <= mismatches;
      replies_pending <= outstanding_replies.size();
   end

endmodule

// File: verif/request_tag_tracker_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// request_tag_tracker_top_tb
// Drives the tag tracker with directed corner requests, then random traffic
// built mostly from well-formed send / header / payload sequences, with a
// phase that fills the tag table, under changing idle patterns.
// ----------------------------------------------------------------------------
module request_tag_tracker_top_tb;
   import rtt_pkg::*;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [METHOD_W-1:0] method;
      logic [LEN_W-1:0]    total_len;
      logic [LEN_W-1:0]    max_resp;
      logic [TAG_W-1:0]    resp_tag;
      logic [LEN_W-1:0]    resp_len;
      logic [KIND_W-1:0]   resp_kind;
      logic [LEN_W-1:0]    consumed;
   } request_type;

   localparam int REQUEST_TARGET = 1250;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [ACTION_W-1:0] req_action;
   logic [METHOD_W-1:0] req_method;
   logic [LEN_W-1:0]    req_request_total_len;
   logic [LEN_W-1:0]    req_max_response_size;
   logic [TAG_W-1:0]    req_response_tag;
   logic [LEN_W-1:0]    req_response_len;
   logic [KIND_W-1:0]   req_response_kind;
   logic [LEN_W-1:0]    req_consumed_bytes;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [TAG_W-1:0]    rsp_tag_out;
   logic [METHOD_W-1:0] rsp_method_out;
   logic [LEN_W-1:0]    rsp_request_payload_len;
   logic [LEN_W-1:0]    rsp_matched_len;
   logic [KIND_W-1:0]   rsp_matched_kind;
   logic [LEN_W-1:0]    rsp_payload_left;
   logic                rsp_header_expected;
   int                  mismatch_count;
   int                  replies_pending;

   logic [TAG_SLOTS-1:0] tag_live;
   logic [LEN_W-1:0]     left_seen;
   logic [ACTION_W-1:0]  last_action;
   int                   requests_sent;

   request_tag_tracker_top u_top (.*);

   request_tag_tracker_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #3_000_000;
      $display("simulation failed");
      $finish;
   end

   // track live tags and the payload count from the responses
   always @(posedge clock) begin
      if (reset) begin
         tag_live  <= '0;
         left_seen <= '0;
      end else if (rsp_valid) begin
         left_seen <= rsp_payload_left;
         if (last_action == ACT_SEND && rsp_status == STAT_OK)
            tag_live[rsp_tag_out] <= 1'b1;
         if (last_action == ACT_HEADER &&
             (rsp_status == STAT_OK || rsp_status == STAT_TOO_LONG))
            tag_live[rsp_tag_out] <= 1'b0;
      end
   end

   function automatic logic [LEN_W-1:0] rand_len();
      case ($urandom_range(3))
         0:       return $urandom_range(0, 2 * HEADER_BYTES);
         1:       return $urandom_range(0, 255);
         2:       return $urandom;
         default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      endcase
   endfunction

   function automatic request_type random_request();
      request_type it;
      it.action    = ACTION_W'($urandom_range(0, 3));
      it.method    = METHOD_W'($urandom);
      it.total_len = $urandom;
      it.max_resp  = $urandom;
      it.resp_tag  = TAG_W'($urandom);
      it.resp_len  = $urandom;
      it.resp_kind = KIND_W'($urandom);
      it.consumed  = $urandom;
      return it;
   endfunction

   function automatic request_type make_send(input logic [METHOD_W-1:0] method,
                                             input logic [LEN_W-1:0] total_len,
                                             input logic [LEN_W-1:0] max_resp);
      request_type it;
      it           = random_request();
      it.action    = ACT_SEND;
      it.method    = method;
      it.total_len = total_len;
      it.max_resp  = max_resp;
      return it;
   endfunction

   function automatic request_type make_header(input logic [TAG_W-1:0] tag,
                                               input logic [LEN_W-1:0] len,
                                               input logic [KIND_W-1:0] kind);
      request_type it;
      it           = random_request();
      it.action    = ACT_HEADER;
      it.resp_tag  = tag;
      it.resp_len  = len;
      it.resp_kind = kind;
      return it;
   endfunction

   function automatic request_type make_payload(input logic [LEN_W-1:0] consumed);
      request_type it;
      it          = random_request();
      it.action   = ACT_PAYLOAD;
      it.consumed = consumed;
      return it;
   endfunction

   function automatic request_type random_send();
      logic [LEN_W-1:0] limit;
      limit = ($urandom_range(9) < 7) ? $urandom_range(40, 4096) : rand_len();
      return make_send(METHOD_W'($urandom), rand_len(), limit);
   endfunction

   task automatic issue(input request_type it);
      int pct;
      int gap;
      case ((requests_sent / 160) % 4)
         1:       pct = 86;
         2:       pct = 8;
         default: pct = 0;
      endcase
      gap = 0;
      while (gap < 64 && $urandom_range(99) < pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                 <= 1'b1;
      req_action            <= it.action;
      req_method            <= it.method;
      req_request_total_len <= it.total_len;
      req_max_response_size <= it.max_resp;
      req_response_tag      <= it.resp_tag;
      req_response_len      <= it.resp_len;
      req_response_kind     <= it.resp_kind;
      req_consumed_bytes    <= it.consumed;
      @(posedge clock);
      while (busy) @(posedge clock);
      last_action = it.action;
      requests_sent++;
   endtask

   task automatic wait_settled();
      start <= 1'b0;
      @(posedge clock);
      while (replies_pending != 0) @(posedge clock);
   endtask

   task automatic drain_payload();
      if (left_seen != 0) issue(make_payload(left_seen));
   endtask

   // header for a live tag followed by payload chunks that use up its count
   task automatic serve_response();
      logic [TAG_W-1:0] tag;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] owed;
      logic [LEN_W-1:0] chunk;
      int               picks;
      int               n;
      wait_settled();
      drain_payload();
      if (tag_live == '0) begin
         issue(random_send());
         wait_settled();
      end
      tag   = TAG_W'($urandom);
      picks = 0;
      while (!tag_live[tag] && picks < TAG_SLOTS) begin
         tag++;
         picks++;
      end
      case ($urandom_range(9))
         0:       len = $urandom;
         1:       len = $urandom_range(0, 3);
         default: len = $urandom_range(0, 40);
      endcase
      issue(make_header(tag, len, KIND_W'($urandom)));
      owed = len;
      n    = 0;
      while (owed != 0 || n == 0) begin
         if (n == 3 || owed < 4 || $urandom_range(2) == 0) chunk = owed;
         else chunk = owed >> $urandom_range(1, 3);
         if (chunk == owed && $urandom_range(9) == 0)
            chunk = owed + 1 + $urandom_range(0, 7);
         issue(make_payload(chunk));
         owed = (chunk > owed) ? '0 : owed - chunk;
         n++;
      end
   endtask

   task automatic fill_table();
      int n;
      wait_settled();
      drain_payload();
      n = TAG_SLOTS - $countones(tag_live) + 3;
      repeat (n) issue(random_send());
      wait_settled();
      for (int k = 0; k < TAG_SLOTS; k++)
         if (tag_live[k] && (k % 8) != 7)
            issue(make_header(TAG_W'(k), '0, KIND_W'($urandom)));
   endtask

   task automatic random_traffic(input int target);
      request_type it;
      int          r;
      while (requests_sent < target) begin
         r = $urandom_range(99);
         if (r < 30) begin
            if ($countones(tag_live) < 48) issue(random_send());
            else serve_response();
         end else if (r < 75) begin
            serve_response();
         end else if (r < 85) begin
            it        = random_request();
            it.action = ACT_HEADER;
            if ($urandom_range(1) == 0) it.resp_tag = TAG_W'($urandom_range(0, 15));
            issue(it);
         end else if (r < 94) begin
            issue(make_payload(($urandom_range(1) == 0) ? $urandom : $urandom_range(0, 8)));
         end else begin
            it        = random_request();
            it.action = ACT_NONE;
            issue(it);
         end
      end
   endtask

   initial begin
      reset                 = 1'b1;
      start                 = 1'b0;
      req_action            = ACT_NONE;
      req_method            = '0;
      req_request_total_len = '0;
      req_max_response_size = '0;
      req_response_tag      = '0;
      req_response_len      = '0;
      req_response_kind     = '0;
      req_consumed_bytes    = '0;
      last_action           = ACT_NONE;
      requests_sent         = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(make_send(8'h00, 32'd0, 32'd0));
      issue(make_send(8'hFF, LEN_W'(HEADER_BYTES), 32'hFFFF_FFFF));
      issue(make_send(8'h5A, LEN_W'(HEADER_BYTES + 1), 32'd100));
      issue(make_send(8'hA5, 32'hFFFF_FFFF, 32'd16));
      issue(make_header(8'd200, 32'd4, 8'h11));
      issue(make_header(8'd0, 32'd1, 8'hFF));
      issue(make_header(8'd1, 32'd0, 8'h22));
      issue(make_payload(32'd2));
      issue(make_header(8'd1, 32'hFFFF_FFFF, 8'h00));
      issue(make_payload(32'hFFFF_FFFE));
      issue(make_payload(32'd1));
      issue(make_payload(32'd0));
      issue(make_header(8'd2, 32'd100, 8'h33));
      issue(make_payload(32'd100));
      issue(make_header(8'd3, 32'd17, 8'h44));
      issue(make_payload(32'hFFFF_FFFF));
      // unused action with every field at its maximum
      issue('1);
      issue(make_header(8'd0, 32'd0, 8'h55));
      issue(make_header(8'd255, 32'd0, 8'h66));
      issue(make_payload(32'd5));
      issue(make_send(8'h00, 32'd0, 32'd0));
      issue(make_header(8'd0, 32'd0, 8'h77));

      random_traffic(500);
      fill_table();
      random_traffic(REQUEST_TARGET);

      wait_settled();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
